// ===== rtl/hmg_pkg.sv =====
// hmg_pkg: shared types, constants and helpers for the henon map generator
// used by hmg_cfg, hmg_mul and henon_map_generator_top; depends on nothing

package hmg_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_A_MIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_A_MAX   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_B       = 2'd3;

  // register reset values
  localparam logic [9:0]         TEXTURE_RESET = 10'd512;
  localparam logic [14:0]        A_MIN_RESET   = 15'd16384;
  localparam logic [14:0]        A_MAX_RESET   = 15'd22938;
  localparam logic signed [15:0] B_RESET       = 16'sd4915;

  // arithmetic constants
  localparam logic [9:0]         TEXTURE_FULL = 10'd1023;
  localparam logic [13:0]        ROUND_Q14    = 14'd8192;
  localparam logic [13:0]        ROUND_TEX    = 14'd512;
  localparam logic [13:0]        ROUND_NONE   = 14'd0;
  localparam logic signed [19:0] ONE_Q14      = 20'sd16384;

  // multiplier operand width and product width
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // configuration register set
  typedef struct packed {
    logic [9:0]         texture;
    logic [14:0]        a_min;
    logic [14:0]        a_max;
    logic signed [15:0] b;
  } cfg_t;

  // request to the shared multiply-add unit
  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
    logic [13:0]      addend;
  } mul_req_t;

  // clamp a 20-bit signed value to the int16 range
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v < -20'sd32768) begin
      r = -16'sd32768;
    end else if (v > 20'sd32767) begin
      r = 16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // 12-bit dac code: offset by half scale, keep the top twelve bits
  function automatic logic [11:0] dac_code(input logic signed [15:0] c);
    return {~c[15], c[14:4]};
  endfunction

endpackage

// ===== rtl/henon_map_generator_top.sv =====
// henon_map_generator_top: henon map source, sequencer and datapath around one multiplier
// depends on hmg_pkg, hmg_cfg, hmg_mul
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   in       | in_valid / in_stall | advance, phase
//   out      | out_valid/out_stall | x_coord, y_coord, x_dac, y_dac
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// an item with advance runs the map update before interpolation, one without
// goes straight to interpolation; every product goes through the single 18x18
// multiplier, one product per cycle, and the map update needs four products, the
// scaling one waiting on the parameter and the square before it.
// rst is synchronous; it clears state and points and reloads the configuration reset values.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds the sequencer in its last step.

module henon_map_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            advance,
  input  logic [11:0]                     phase,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              x_coord,
  output logic signed [15:0]              y_coord,
  output logic [11:0]                     x_dac,
  output logic [11:0]                     y_dac,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hmg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hmg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN,
    S_SQ,
    S_SCALE,
    S_BX,
    S_UPD,
    S_IX,
    S_IY,
    S_OUT
  } state_t;

  state_t                               state;
  hmg_pkg::cfg_t                        cfg;
  hmg_pkg::mul_req_t                    req;
  logic signed [hmg_pkg::PROD_W-1:0]    prod;

  logic signed [15:0] prev_x, prev_y, cur_x, cur_y;
  logic [11:0]        phase_reg;
  logic [14:0]        a_reg;
  logic signed [15:0] nx_reg;
  logic signed [15:0] ix_reg;

  logic signed [16:0] span;
  logic signed [16:0] dx, dy;
  logic signed [16:0] a_sum;
  logic signed [19:0] nx_wide, ny_wide, ix_wide, iy_wide;
  logic               in_accept;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !(out_valid && out_stall);

  // configuration registers
  hmg_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // shared multiplier
  hmg_mul u_mul (
    .clk  (clk),
    .req  (req),
    .prod (prod)
  );

  // differences feeding the multiplier
  assign span = $signed({2'b00, cfg.a_max}) - $signed({2'b00, cfg.a_min});
  assign dx   = $signed({cur_x[15], cur_x}) - $signed({prev_x[15], prev_x});
  assign dy   = $signed({cur_y[15], cur_y}) - $signed({prev_y[15], prev_y});

  // post-processing of the last product
  assign a_sum   = $signed({2'b00, cfg.a_min}) + $signed({prod[25], prod[25:10]});
  assign nx_wide = hmg_pkg::ONE_Q14 + $signed({{4{cur_y[15]}}, cur_y})
                 - $signed({{2{prod[31]}}, prod[31:14]});
  assign ny_wide = $signed({{2{prod[31]}}, prod[31:14]});
  assign ix_wide = $signed({{4{prev_x[15]}}, prev_x}) + $signed({{2{prod[29]}}, prod[29:12]});
  assign iy_wide = $signed({{4{prev_y[15]}}, prev_y}) + $signed({{2{prod[29]}}, prod[29:12]});

  // operand selection per step
  always_comb begin
    req.en     = 1'b0;
    req.op_a   = '0;
    req.op_b   = '0;
    req.addend = hmg_pkg::ROUND_NONE;
    case (state)
      S_SPAN: begin
        req.en     = 1'b1;
        req.op_a   = {span[16], span};
        req.op_b   = {8'b0, cfg.texture};
        req.addend = hmg_pkg::ROUND_TEX;
      end
      S_SQ: begin
        req.en     = 1'b1;
        req.op_a   = {{2{cur_x[15]}}, cur_x};
        req.op_b   = {{2{cur_x[15]}}, cur_x};
        req.addend = hmg_pkg::ROUND_Q14;
      end
      S_SCALE: begin
        req.en     = 1'b1;
        req.op_a   = prod[31:14];
        req.op_b   = {3'b000, a_reg};
        req.addend = hmg_pkg::ROUND_Q14;
      end
      S_BX: begin
        req.en     = 1'b1;
        req.op_a   = {{2{cur_x[15]}}, cur_x};
        req.op_b   = {{2{cfg.b[15]}}, cfg.b};
      end
      S_IX: begin
        req.en     = 1'b1;
        req.op_a   = {dx[16], dx};
        req.op_b   = {6'b0, phase_reg};
      end
      S_IY: begin
        req.en     = 1'b1;
        req.op_a   = {dy[16], dy};
        req.op_b   = {6'b0, phase_reg};
      end
      default: ;
    endcase
  end

  // sequencer, map state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
    end else begin
      // taken result leaves; the final step reloads it itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            phase_reg <= phase;
            state     <= advance ? S_SPAN : S_IX;
          end
        end
        S_SPAN: state <= S_SQ;
        S_SQ: begin
          // exact maximum at full texture
          a_reg <= (cfg.texture == hmg_pkg::TEXTURE_FULL) ? cfg.a_max : a_sum[14:0];
          state <= S_SCALE;
        end
        S_SCALE: state <= S_BX;
        S_BX: begin
          nx_reg <= hmg_pkg::sat16(nx_wide);
          state  <= S_UPD;
        end
        S_UPD: begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          cur_x  <= nx_reg;
          cur_y  <= hmg_pkg::sat16(ny_wide);
          state  <= S_IX;
        end
        S_IX: state <= S_IY;
        S_IY: begin
          ix_reg <= hmg_pkg::sat16(ix_wide);
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            x_coord   <= ix_reg;
            y_coord   <= hmg_pkg::sat16(iy_wide);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // dac codes from the registered coordinates
  assign x_dac = hmg_pkg::dac_code(x_coord);
  assign y_dac = hmg_pkg::dac_code(y_coord);

  // an item without advance goes straight to interpolation
  a_no_adv: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !advance) |=> (state == S_IX))
    else $error("item without advance did not skip the map update");

  // the current point and the previous x move only in the update step
  a_pts_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_UPD) |=> ($stable(cur_x) && $stable(cur_y) && $stable(prev_x)))
    else $error("map point changed outside the update step");

  // a new result appears only from the final step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the final step");

  // a blocked output holds the sequencer in its final step
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("result overwritten while the output was stalled");

endmodule

// ===== rtl/hmg_mul.sv =====
// hmg_mul: shared signed multiply-add unit with registered product
// depends on hmg_pkg (mul_req_t, widths)

module hmg_mul (
  input  logic                           clk,
  input  hmg_pkg::mul_req_t              req,
  output logic signed [hmg_pkg::PROD_W-1:0] prod
);

  logic signed [hmg_pkg::PROD_W-1:0] sum;

  // product plus a small non-negative rounding term
  assign sum = $signed(req.op_a) * $signed(req.op_b)
             + $signed({{(hmg_pkg::PROD_W - 14){1'b0}}, req.addend});

  // product register, loaded only when a step issues
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= sum;
    end
  end

endmodule

// ===== rtl/hmg_cfg.sv =====
// hmg_cfg: configuration registers of the henon map generator
// depends on hmg_pkg (cfg_t, register indexes, reset values)

module hmg_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [hmg_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [hmg_pkg::CFG_DATA_W-1:0]    wr_data,
  output hmg_pkg::cfg_t                     cfg
);

  // register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.texture <= hmg_pkg::TEXTURE_RESET;
      cfg.a_min   <= hmg_pkg::A_MIN_RESET;
      cfg.a_max   <= hmg_pkg::A_MAX_RESET;
      cfg.b       <= hmg_pkg::B_RESET;
    end else if (wr_en) begin
      case (wr_index)
        hmg_pkg::REG_TEXTURE: cfg.texture <= wr_data[9:0];
        hmg_pkg::REG_A_MIN:   cfg.a_min   <= wr_data[14:0];
        hmg_pkg::REG_A_MAX:   cfg.a_max   <= wr_data[14:0];
        hmg_pkg::REG_B:       cfg.b       <= $signed(wr_data);
        default: ;
      endcase
    end
  end

endmodule
